[sv/path_velocity_profiler_defines.svh]
// ----------------------------------------------------------------------------
// Path velocity profiler assertion macros
// Shared assertion shorthands, sampled on clk, idle during reset.
// ----------------------------------------------------------------------------
`ifndef PATH_VELOCITY_PROFILER_DEFINES_SVH
`define PATH_VELOCITY_PROFILER_DEFINES_SVH

// same-cycle implication
`define PVP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pvp assertion failed");

// next-cycle implication
`define PVP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pvp assertion failed");

`endif

[sv/pvp_pkg.sv]
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types and constants of the path velocity profiler.
// ----------------------------------------------------------------------------
`default_nettype none
package pvp_pkg;
	localparam int unsigned IDX_W = 6;

	typedef enum logic [1:0] {
		REG_MAX_VEL  = 2'd0,
		REG_MAX_ACC  = 2'd1,
		REG_MAX_ANG  = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        k;
		logic               last;
	} item_t;
endpackage
`default_nettype wire

[sv/pvp_front.sv]
// ----------------------------------------------------------------------------
// pvp_front
// Input side: two-entry queue of path points ahead of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module pvp_front
	import pvp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	output logic       item_valid,
	output item_t      item,
	input  wire logic  item_pop
);
	item_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rp_q];
	assign push       = in_valid && in_ready;
	assign pop        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

[sv/pvp_div.sv]
// ----------------------------------------------------------------------------
// pvp_div
// Restoring divider, 64-bit dividend by 33-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pvp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [32:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [63:0] dvd_q;
	logic [32:0] dvs_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] r;
	logic        qb;

	assign r        = {rem_q, dvd_q[63]};
	assign qb       = (r >= {1'b0, dvs_q});
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qb ? 33'(r - {1'b0, dvs_q}) : r[32:0];
			dvd_q <= {dvd_q[62:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[sv/pvp_sqrt.sv]
// ----------------------------------------------------------------------------
// pvp_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pvp_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [35:0] r, trial;
	logic        hit;

	assign r     = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign hit   = (r >= trial);
	assign root  = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= hit ? 34'(r - trial) : r[33:0];
			root_q <= {root_q[30:0], hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[sv/pvp_back.sv]
// ----------------------------------------------------------------------------
// pvp_back
// Sequencer: caps, segment lengths, backward and forward passes, results.
// ----------------------------------------------------------------------------
`default_nettype none
module pvp_back
	import pvp_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire item_t       item,
	output logic             item_pop,
	input  wire logic [31:0] max_vel,
	input  wire logic [31:0] max_acc,
	input  wire logic [31:0] max_ang,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [IDX_W-1:0] point_index,
	output logic [31:0]      velocity,
	output logic [31:0]      acceleration,
	output logic             last_result,
	output logic             overflowed
);
	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_CAP, S_CAPW, S_SEG, S_SQA, S_SQB, S_SQS, S_SQW, S_STORE, S_LAST,
		S_B_RD, S_B_M1, S_B_M2, S_B_SQ, S_B_W,
		S_F_RD, S_F_M1, S_F_M2, S_F_M3, S_F_W, S_F_M4, S_F_M5, S_F_DW, S_F_OUT
	} state_t;

	state_t             st_q;
	item_t              itm_q;
	logic signed [31:0] px_q, py_q;
	logic [CW-1:0]      cnt_q, n_q;
	logic               drop_q;
	logic [31:0]        cap_q;
	logic [31:0]        da_q, db_q;
	logic               half_q;
	logic [63:0]        acc_q, s0_q, t_q;
	logic [AW-1:0]      i_q;
	logic [31:0]        vnext_q, cur_q, d_q, a_q;

	logic [31:0] seg_mem [MAX_POINTS];
	logic [31:0] spd_mem [MAX_POINTS];
	logic [31:0] seg_rd_q, spd_rd_q;
	logic [AW-1:0] seg_ra, spd_ra, seg_wa, spd_wa;
	logic        seg_we, spd_we;
	logic [31:0] seg_wd, spd_wd;

	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_q;
	logic [63:0] mul_sat;
	logic [64:0] sum;
	logic [63:0] sum_sat;

	logic        div_start, div_done, sq_start, sq_done;
	logic [63:0] div_dvd, quo, sq_rad;
	logic [32:0] div_dvs;
	logic [31:0] root;
	logic [32:0] root2;
	logic [32:0] dx, dy;
	logic [31:0] ax, ay, bmin;
	logic [AW-1:0] last_a;

	assign mul_sat = (mul_q[65:64] != 2'b00) ? '1 : mul_q[63:0];
	assign sum     = {1'b0, mul_q[63:0]} + {1'b0, t_q};
	assign sum_sat = sum[64] ? '1 : sum[63:0];
	// coordinate differences taken on the raw 32-bit codes
	assign dx      = {1'b0, itm_q.x} - {1'b0, px_q};
	assign dy      = {1'b0, itm_q.y} - {1'b0, py_q};
	assign ax      = dx[32] ? 32'(-dx) : dx[31:0];
	assign ay      = dy[32] ? 32'(-dy) : dy[31:0];
	assign root2   = half_q ? {root, 1'b0} : {1'b0, root};
	assign bmin    = (root < cur_q) ? root : cur_q;
	assign last_a  = AW'(n_q - CW'(1));

	// multiplier operand select, start pulses, memory ports
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = {16'd0, max_ang, 16'd0};
		div_dvs   = {1'b0, itm_q.k};
		sq_start  = 1'b0;
		sq_rad    = sum_sat;
		seg_we    = 1'b0;
		seg_wa    = AW'(cnt_q - CW'(1));
		seg_wd    = root2[32] ? '1 : root2[31:0];
		spd_we    = 1'b0;
		spd_wa    = AW'(cnt_q);
		spd_wd    = cap_q;
		seg_ra    = i_q;
		spd_ra    = i_q;
		item_pop  = 1'b0;
		case (st_q)
			S_IDLE: item_pop = item_valid;
			S_CAP: div_start = (cnt_q != CW'(MAX_POINTS)) && (itm_q.k != '0);
			S_SQA: begin
				mul_a = {1'b0, da_q};
				mul_b = {1'b0, da_q};
			end
			S_SQB: begin
				mul_a = {1'b0, db_q};
				mul_b = {1'b0, db_q};
			end
			S_SQS: begin
				sq_start = 1'b1;
				sq_rad   = acc_q + mul_q[63:0];
			end
			S_SQW: seg_we = sq_done;
			S_STORE: spd_we = 1'b1;
			S_LAST: begin
				spd_we = itm_q.last;
				spd_wa = AW'(cnt_q - CW'(1));
				spd_wd = '0;
			end
			S_B_M1, S_F_M1: begin
				mul_a = {max_acc, 1'b0};
				mul_b = {1'b0, seg_rd_q};
			end
			S_B_M2: begin
				mul_a = {1'b0, vnext_q};
				mul_b = {1'b0, vnext_q};
			end
			S_B_SQ: sq_start = 1'b1;
			S_B_W: begin
				spd_we = sq_done;
				spd_wa = i_q;
				spd_wd = bmin;
			end
			S_F_RD: spd_ra = AW'(i_q + AW'(1));
			S_F_M2: begin
				mul_a = {1'b0, vnext_q};
				mul_b = {1'b0, vnext_q};
			end
			S_F_M3: sq_start = 1'b1;
			S_F_M4: begin
				mul_a = {1'b0, cur_q};
				mul_b = {1'b0, cur_q};
			end
			S_F_M5: begin
				div_start = (d_q != '0);
				div_dvd   = (mul_q[63:0] >= s0_q) ? mul_q[63:0] - s0_q
				                                   : s0_q - mul_q[63:0];
				div_dvs   = {d_q, 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[seg_wa] <= seg_wd;
		end
		seg_rd_q <= seg_mem[seg_ra];
	end

	always_ff @(posedge clk) begin
		if (spd_we) begin
			spd_mem[spd_wa] <= spd_wd;
		end
		spd_rd_q <= spd_mem[spd_ra];
	end

	pvp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (quo)
	);

	pvp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			px_q        <= '0;
			py_q        <= '0;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			out_valid   <= 1'b0;
			itm_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			cap_q       <= '0;
			da_q        <= '0;
			db_q        <= '0;
			half_q      <= 1'b0;
			acc_q       <= '0;
			s0_q        <= '0;
			t_q         <= '0;
			vnext_q     <= '0;
			cur_q       <= '0;
			d_q         <= '0;
			a_q         <= '0;
			point_index <= '0;
			velocity    <= '0;
			acceleration <= '0;
			last_result <= 1'b0;
			overflowed  <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (item_valid) begin
						itm_q <= item;
						st_q  <= S_CAP;
					end
				end
				S_CAP: begin
					if (cnt_q == CW'(MAX_POINTS)) begin
						drop_q <= 1'b1;
						st_q   <= S_LAST;
					end else if (itm_q.k != '0) begin
						st_q <= S_CAPW;
					end else begin
						cap_q <= max_vel;
						st_q  <= S_SEG;
					end
				end
				S_CAPW: begin
					if (div_done) begin
						cap_q <= (quo < {32'd0, max_vel}) ? quo[31:0] : max_vel;
						st_q  <= S_SEG;
					end
				end
				S_SEG: begin
					if (cnt_q == '0) begin
						st_q <= S_STORE;
					end else begin
						// halve both when either difference needs all 32 bits
						half_q <= ax[31] || ay[31];
						da_q   <= (ax[31] || ay[31]) ? {1'b0, ax[31:1]} : ax;
						db_q   <= (ax[31] || ay[31]) ? {1'b0, ay[31:1]} : ay;
						st_q   <= S_SQA;
					end
				end
				S_SQA: st_q <= S_SQB;
				S_SQB: begin
					acc_q <= mul_q[63:0];
					st_q  <= S_SQS;
				end
				S_SQS: st_q <= S_SQW;
				S_SQW: begin
					if (sq_done) begin
						st_q <= S_STORE;
					end
				end
				S_STORE: begin
					px_q  <= itm_q.x;
					py_q  <= itm_q.y;
					cnt_q <= cnt_q + CW'(1);
					st_q  <= S_LAST;
				end
				S_LAST: begin
					if (!itm_q.last) begin
						st_q <= S_IDLE;
					end else begin
						n_q     <= cnt_q;
						vnext_q <= '0;
						if (cnt_q > CW'(1)) begin
							i_q  <= AW'(cnt_q - CW'(2));
							st_q <= S_B_RD;
						end else begin
							st_q <= S_F_RD;
							i_q  <= '0;
						end
					end
				end
				S_B_RD: st_q <= S_B_M1;
				S_B_M1: begin
					cur_q <= (i_q == '0) ? '0 : spd_rd_q;
					st_q  <= S_B_M2;
				end
				S_B_M2: begin
					t_q  <= mul_sat;
					st_q <= S_B_SQ;
				end
				S_B_SQ: st_q <= S_B_W;
				S_B_W: begin
					if (sq_done) begin
						vnext_q <= bmin;
						if (i_q == '0) begin
							vnext_q <= '0;
							st_q    <= S_F_RD;
						end else begin
							i_q  <= i_q - AW'(1);
							st_q <= S_B_RD;
						end
					end
				end
				// forward pass: vnext_q holds the speed at point i
				S_F_RD: begin
					if (i_q == last_a) begin
						a_q  <= '0;
						st_q <= S_F_OUT;
					end else begin
						st_q <= S_F_M1;
					end
				end
				S_F_M1: begin
					d_q   <= seg_rd_q;
					cur_q <= spd_rd_q;
					st_q  <= S_F_M2;
				end
				S_F_M2: begin
					t_q  <= mul_sat;
					st_q <= S_F_M3;
				end
				S_F_M3: begin
					s0_q <= mul_q[63:0];
					st_q <= S_F_W;
				end
				S_F_W: begin
					if (sq_done) begin
						cur_q <= bmin;
						st_q  <= S_F_M4;
					end
				end
				S_F_M4: st_q <= S_F_M5;
				S_F_M5: begin
					acc_q <= mul_q[63:0];
					if (d_q == '0) begin
						a_q  <= '0;
						st_q <= S_F_OUT;
					end else begin
						st_q <= S_F_DW;
					end
				end
				S_F_DW: begin
					if (div_done) begin
						if (acc_q >= s0_q) begin
							a_q <= (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
						end else begin
							a_q <= (quo >= 64'h8000_0000) ? 32'h8000_0000
							                               : 32'(-quo[31:0]);
						end
						st_q <= S_F_OUT;
					end
				end
				S_F_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						point_index  <= IDX_W'(i_q);
						velocity     <= vnext_q;
						acceleration <= a_q;
						last_result  <= (i_q == last_a);
						overflowed   <= drop_q;
						if (i_q == last_a) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
							px_q   <= '0;
							py_q   <= '0;
							st_q   <= S_IDLE;
						end else begin
							vnext_q <= cur_q;
							i_q     <= i_q + AW'(1);
							st_q    <= S_F_RD;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/path_velocity_profiler.sv]
// ----------------------------------------------------------------------------
// path_velocity_profiler
// Curvature-limited trapezoidal speed profile over a stored path, Q16.16.
// ----------------------------------------------------------------------------
// Channel  Signals                                   Direction
// in       in_valid/in_ready, x,y,curvature,last     point beat in
// out      out_valid/out_ready, index,vel,acc,flags  result beat out
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  register write
//
// Work: a point with zero curvature and none stored skips both units; others
// may need a cap divide and a segment root. After the last point the backward
// pass runs a root per segment and the forward pass a root per segment plus a
// divide per segment of nonzero length.
// Reset: asynchronous, clears control state; stores need no clearing.
// Stalls: a two-beat queue decouples input; results wait in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "path_velocity_profiler_defines.svh"
module path_velocity_profiler
	import pvp_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] x_position,
	input  wire logic [31:0] y_position,
	input  wire logic [31:0] curvature,
	input  wire logic        last_point,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       point_index,
	output logic [31:0]      velocity,
	output logic [31:0]      acceleration,
	output logic             last_result,
	output logic             overflowed,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic [31:0] max_vel_q, max_acc_q, max_ang_q;
	item_t       in_item, item;
	logic        item_valid, item_pop;

	assign cfg_ready = 1'b1;
	assign in_item   = '{x: x_position, y: y_position, k: curvature, last: last_point};

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vel_q <= 32'h0001_0000;
			max_acc_q <= 32'h0001_0000;
			max_ang_q <= 32'h0001_0000;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_VEL: max_vel_q <= cfg_data;
				REG_MAX_ACC: max_acc_q <= cfg_data;
				REG_MAX_ANG: max_ang_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pvp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	pvp_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop),
		.max_vel      (max_vel_q),
		.max_acc      (max_acc_q),
		.max_ang      (max_ang_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_index  (point_index),
		.velocity     (velocity),
		.acceleration (acceleration),
		.last_result  (last_result),
		.overflowed   (overflowed)
	);

	// final point of a path carries no acceleration and zero speed
	`PVP_ASSERT_IMP(a_last_acc_zero, out_valid && last_result, acceleration == 32'd0)
	`PVP_ASSERT_IMP(a_last_vel_zero, out_valid && last_result, velocity == 32'd0)
	// nothing follows the final result straight away
	`PVP_ASSERT_NXT(a_last_then_idle, out_valid && out_ready && last_result, !out_valid)
endmodule
`default_nettype wire
